[design/gas_sensor_adc_to_ppm_core_macros.svh]
// ----------------------------------------------------------------------------
// Gas sensor ppm core assertion macros
// Shared concurrent assertion forms used by the core's checks.
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_ADC_TO_PPM_CORE_MACROS_SVH
`define GAS_SENSOR_ADC_TO_PPM_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSAPPM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GSAPPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/gsappm_pkg.sv]
// ----------------------------------------------------------------------------
// Gas sensor ppm package
// Register indexes, default settings and elaboration-time constant helpers.
// ----------------------------------------------------------------------------
package gsappm_pkg;

    localparam int ADC_BITS_DEFAULT = 12;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LOAD_RES       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAN_AIR_RES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_EXPONENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_LEVEL    = 3'd4;

    localparam logic [15:0] LOAD_RES_RST       = 16'd2560;
    localparam logic [15:0] CLEAN_AIR_RES_RST  = 16'd2560;
    localparam logic [23:0] CURVE_SCALE_RST    = 24'd147008;
    localparam logic [15:0] CURVE_EXPONENT_RST = 16'hDC73;
    localparam logic [31:0] ALERT_LEVEL_RST    = 32'd4800;

    typedef logic [30:0] t_mant;

    // Integer square root, bit by bit.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.30, each one the square root of the one before.
    function automatic logic [31:0] exp_root(input int k);
        logic [63:0] c;
        c = 64'd2 << 30;
        for (int j = 1; j <= k; j++) begin
            c = isqrt64(c << 30);
        end
        return c[31:0];
    endfunction

endpackage

[design/gas_sensor_adc_to_ppm_core.sv]
// ----------------------------------------------------------------------------
// Gas sensor ADC to ppm conversion core
// Power-law resistive gas sensor model computed in a fixed-point pipeline.
// ----------------------------------------------------------------------------
// The core takes one converter sample per item and returns one result item:
// the concentration ppm = a * (Rs/R0)^b in unsigned Q28.4, an alert flag and
// a saturation flag. It is a 41-stage pipeline that accepts a new item in every
// cycle while the output side keeps up. The whole pipeline advances as one
// unit, so it holds still while a finished result waits and nothing is lost
// or repeated. Most of its depth comes from the two chains of sixteen 31-bit
// multiplies, one for the log2 fraction (repeated squaring) and one for the
// exp2 fraction (product of root constants), each multiply having a register
// stage of its own.
// Configuration registers must be written only while no item is in flight;
// the configuration port is always ready.
`include "gas_sensor_adc_to_ppm_core_macros.svh"

module gas_sensor_adc_to_ppm_core #(
    parameter int ADC_BITS = gsappm_pkg::ADC_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ADC_BITS-1:0]               i_adc_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [31:0]                       o_ppm_value,
    output logic                              o_over_level,
    output logic                              o_saturated,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gsappm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gsappm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gsappm_pkg::*;

    // Product widths and the fixed-point log/exp widths that follow from them.
    localparam int NW    = ADC_BITS + 16;
    localparam int MSBW  = $clog2(NW);
    localparam int LQW   = MSBW + 16;
    localparam int LW    = LQW + 1;
    localparam int PW    = LW + 16;
    localparam int EW    = PW - 12;
    localparam int TW    = EW + 1;
    localparam int SW    = TW - 16 + 1;
    localparam int VW    = 24 + 31;
    localparam int STEPS = 16;
    localparam int DEPTH = 3 + STEPS + 3 + STEPS + 3;
    localparam logic [ADC_BITS-1:0] FS = {ADC_BITS{1'b1}};

    // Configuration registers.
    logic [15:0] r_load_res;
    logic [15:0] r_clean_air_res;
    logic [23:0] r_curve_scale;
    logic [15:0] r_curve_exponent;
    logic [31:0] r_alert_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_res       <= LOAD_RES_RST;
            r_clean_air_res  <= CLEAN_AIR_RES_RST;
            r_curve_scale    <= CURVE_SCALE_RST;
            r_curve_exponent <= CURVE_EXPONENT_RST;
            r_alert_level    <= ALERT_LEVEL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LOAD_RES:       r_load_res       <= i_cfg_data[15:0];
                REG_CLEAN_AIR_RES:  r_clean_air_res  <= i_cfg_data[15:0];
                REG_CURVE_SCALE:    r_curve_scale    <= i_cfg_data[23:0];
                REG_CURVE_EXPONENT: r_curve_exponent <= i_cfg_data[15:0];
                REG_ALERT_LEVEL:    r_alert_level    <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves together unless a finished result is held.
    logic w_adv;
    logic w_in_acc;
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] r_zero;

    assign w_adv      = !r_vld[DEPTH-1] || i_out_ready;
    assign o_in_ready = w_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Stage 0: ratio numerator and denominator.
    logic [ADC_BITS-1:0] w_adc;
    logic [ADC_BITS-1:0] w_rem;
    logic [15:0]         w_r0;
    logic [NW-1:0]       w_num;
    logic [NW-1:0]       w_den;
    logic [NW-1:0]       r_num;
    logic [NW-1:0]       r_den;

    always_comb begin
        w_adc = (i_adc_sample == '0) ? {{(ADC_BITS-1){1'b0}}, 1'b1} : i_adc_sample;
        w_rem = FS - w_adc;
        w_r0  = (r_clean_air_res == '0) ? 16'd1 : r_clean_air_res;
        w_num = {{16{1'b0}}, w_rem} * {{ADC_BITS{1'b0}}, r_load_res};
        w_den = {{16{1'b0}}, w_adc} * {{ADC_BITS{1'b0}}, w_r0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], w_in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num  <= w_num;
            r_den  <= w_den;
            r_zero <= {r_zero[DEPTH-2:0], (w_num == '0)};
        end
    end

    // Stage 1: leading one position of both operands.
    logic [MSBW-1:0] w_msbn;
    logic [MSBW-1:0] w_msbd;
    logic [NW-1:0]   r_num1;
    logic [NW-1:0]   r_den1;
    logic [MSBW-1:0] r_msbn;
    logic [MSBW-1:0] r_msbd;

    always_comb begin
        w_msbn = '0;
        w_msbd = '0;
        for (int i = 0; i < NW; i++) begin
            if (r_num[i]) w_msbn = MSBW'(i);
            if (r_den[i]) w_msbd = MSBW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num1 <= r_num;
            r_den1 <= r_den;
            r_msbn <= w_msbn;
            r_msbd <= w_msbd;
        end
    end

    // Stage 2: normalize to a Q1.30 mantissa.
    logic [NW+29:0]  w_extn;
    logic [NW+29:0]  w_extd;
    t_mant           r_mn [0:STEPS];
    t_mant           r_md [0:STEPS];
    logic [15:0]     r_fn [0:STEPS];
    logic [15:0]     r_fd [0:STEPS];
    logic [MSBW-1:0] r_in [0:STEPS];
    logic [MSBW-1:0] r_id [0:STEPS];

    assign w_extn = {r_num1, 30'b0} >> r_msbn;
    assign w_extd = {r_den1, 30'b0} >> r_msbd;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mn[0] <= w_extn[30:0];
            r_md[0] <= w_extd[30:0];
            r_fn[0] <= '0;
            r_fd[0] <= '0;
            r_in[0] <= r_msbn;
            r_id[0] <= r_msbd;
        end
    end

    // Log2 fraction: one squaring per stage, one result bit per squaring.
    for (genvar j = 0; j < STEPS; j++) begin : g_log
        logic [61:0] w_sqn;
        logic [61:0] w_sqd;
        logic [31:0] w_tn;
        logic [31:0] w_td;
        logic [15:0] w_bit;

        assign w_sqn = {31'b0, r_mn[j]} * {31'b0, r_mn[j]};
        assign w_sqd = {31'b0, r_md[j]} * {31'b0, r_md[j]};
        assign w_tn  = w_sqn[61:30];
        assign w_td  = w_sqd[61:30];
        assign w_bit = 16'd1 << (STEPS - 1 - j);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_mn[j+1] <= w_tn[31] ? w_tn[31:1] : w_tn[30:0];
                r_md[j+1] <= w_td[31] ? w_td[31:1] : w_td[30:0];
                r_fn[j+1] <= w_tn[31] ? (r_fn[j] | w_bit) : r_fn[j];
                r_fd[j+1] <= w_td[31] ? (r_fd[j] | w_bit) : r_fd[j];
                r_in[j+1] <= r_in[j];
                r_id[j+1] <= r_id[j];
            end
        end
    end

    // Log ratio, exponent multiply, then the split into integer and fraction.
    logic signed [LW-1:0] r_l;
    logic signed [PW-1:0] r_prod;
    logic signed [EW-1:0] w_e;
    logic signed [TW-1:0] w_t;
    logic signed [SW-1:0] w_s;
    t_mant                r_em [0:STEPS];
    logic [15:0]          r_ef [0:STEPS];
    logic signed [SW-1:0] r_es [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l    <= $signed({1'b0, r_in[STEPS], r_fn[STEPS]})
                    - $signed({1'b0, r_id[STEPS], r_fd[STEPS]});
            r_prod <= PW'(r_l) * PW'($signed(r_curve_exponent));
        end
    end

    // A zero ratio forces e to zero here (result a); the output stage handles nonzero b.
    always_comb begin
        w_e = r_zero[3 + STEPS + 1] ? '0 : EW'(r_prod >>> 12);
        w_t = TW'(w_e) - TW'(signed'(32'sd262144));
        w_s = SW'(w_t >>> 16) - SW'(signed'(32'sd30));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_em[0] <= t_mant'(31'd1 << 30);
            r_ef[0] <= w_t[15:0];
            r_es[0] <= w_s;
        end
    end

    // Exp2 fraction: multiply in the root constant for each set fraction bit.
    for (genvar k = 1; k <= STEPS; k++) begin : g_exp
        localparam logic [31:0] C = exp_root(k);
        logic [62:0] w_p;

        assign w_p = {32'b0, r_em[k-1]} * {31'b0, C};

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_em[k] <= r_ef[k-1][STEPS-k] ? w_p[60:30] : r_em[k-1];
                r_ef[k] <= r_ef[k-1];
                r_es[k] <= r_es[k-1];
            end
        end
    end

    // Scale by a, then place the binary point.
    logic [VW-1:0]        r_v;
    logic signed [SW-1:0] r_vs;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v  <= {31'b0, r_curve_scale} * {24'b0, r_em[STEPS]};
            r_vs <= r_es[STEPS];
        end
    end

    logic [31:0]   w_raw;
    logic          w_rsat;
    logic [VW-1:0] w_shl;
    logic [VW-1:0] w_shr;
    logic [VW-1:0] w_hi;
    logic [SW-1:0] w_ns;
    logic [31:0]   r_raw;
    logic          r_rsat;

    always_comb begin
        w_shl = '0;
        w_shr = '0;
        w_hi  = '0;
        w_ns  = '0;
        if (!r_vs[SW-1]) begin
            if (r_vs >= SW'(32)) begin
                w_rsat = (r_v != '0);
                w_raw  = '0;
            end else begin
                w_shl  = r_v << r_vs[4:0];
                w_hi   = r_v >> (6'd32 - {1'b0, r_vs[4:0]});
                w_rsat = (w_hi != '0);
                w_raw  = w_shl[31:0];
            end
        end else begin
            w_ns   = -r_vs;
            w_shr  = (w_ns > SW'(63)) ? '0 : (r_v >> w_ns[5:0]);
            w_rsat = (w_shr[VW-1:32] != '0);
            w_raw  = w_shr[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_raw  <= w_raw;
            r_rsat <= w_rsat;
        end
    end

    // Output stage: zero-ratio cases, saturation and the alert compare.
    logic        w_zero;
    logic        w_bneg;
    logic        w_bpos;
    logic        w_sat;
    logic [31:0] w_ppm;
    logic [31:0] r_ppm;
    logic        r_over;
    logic        r_sat;

    always_comb begin
        w_zero = r_zero[DEPTH-2];
        w_bneg = r_curve_exponent[15];
        w_bpos = !r_curve_exponent[15] && (r_curve_exponent != '0);
        if (w_zero && w_bneg) begin
            w_sat = 1'b1;
        end else if (w_zero && w_bpos) begin
            w_sat = 1'b0;
        end else begin
            w_sat = r_rsat;
        end
        if (w_sat) begin
            w_ppm = '1;
        end else if (w_zero && w_bpos) begin
            w_ppm = '0;
        end else begin
            w_ppm = r_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ppm  <= w_ppm;
            r_over <= (w_ppm > r_alert_level);
            r_sat  <= w_sat;
        end
    end

    assign o_out_valid  = r_vld[DEPTH-1];
    assign o_ppm_value  = r_ppm;
    assign o_over_level = r_over;
    assign o_saturated  = r_sat;

    `GSAPPM_ASSERT_IMPLIES(a_sat_is_max, i_clk, i_rst_n, o_out_valid && o_saturated, o_ppm_value == 32'hFFFF_FFFF)
    `GSAPPM_ASSERT_IMPLIES(a_over_above, i_clk, i_rst_n, o_out_valid && o_over_level, o_ppm_value > r_alert_level)
    `GSAPPM_ASSERT_IMPLIES(a_hold_blocks, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    `GSAPPM_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0])

endmodule
